/* rtl/core/md5_pkg.sv */
// ----------------------------------------------------------------------------
// MD5 digest package
// Shared types, initial chaining values and per-round tables for the MD5
// digest core.
// ----------------------------------------------------------------------------
package md5_pkg;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;
    localparam logic [7:0]  PAD_BYTE = 8'h80;
    localparam int unsigned WORDS = 16;

    typedef logic [31:0] t_word;
    typedef logic [5:0]  t_round;
    typedef logic [3:0]  t_widx;

    function automatic t_word round_k(input t_round r);
        t_word k;
        case (r)
            6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;  default: k = 32'heb86d391;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] round_s(input t_round r);
        logic [4:0] s;
        case ({r[5:4], r[1:0]})
            4'b0000: s = 5'd7;   4'b0001: s = 5'd12;
            4'b0010: s = 5'd17;  4'b0011: s = 5'd22;
            4'b0100: s = 5'd5;   4'b0101: s = 5'd9;
            4'b0110: s = 5'd14;  4'b0111: s = 5'd20;
            4'b1000: s = 5'd4;   4'b1001: s = 5'd11;
            4'b1010: s = 5'd16;  4'b1011: s = 5'd23;
            4'b1100: s = 5'd6;   4'b1101: s = 5'd10;
            4'b1110: s = 5'd15;  default: s = 5'd21;
        endcase
        return s;
    endfunction

    function automatic t_widx round_g(input t_round r);
        t_widx i;
        t_widx g;
        i = r[3:0];
        case (r[5:4])
            2'd0:    g = i;
            2'd1:    g = t_widx'(i * 4'd5 + 4'd1);
            2'd2:    g = t_widx'(i * 4'd3 + 4'd5);
            default: g = t_widx'(i * 4'd7);
        endcase
        return g;
    endfunction

endpackage

/* rtl/core/md5_digest_stream.sv */
// ----------------------------------------------------------------------------
// MD5 digest stream
// Streaming MD5 over bytes; emits the digest as four words per message.
// ----------------------------------------------------------------------------
// Bytes are accepted only while idle; a full block is compressed in the single
// shared round unit, one round per cycle.
// The end of a message adds padding writes and one or two compressions; the
// digest is offered after the final compression, or later while the previous
// digest is still held.
// Synchronous active-low reset restores the MD5 initial words and a zero count.
// ----------------------------------------------------------------------------
module md5_digest_stream (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_valid,
    input  logic        i_last,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word_a,
    output logic [31:0] o_digest_word_b,
    output logic [31:0] o_digest_word_c,
    output logic [31:0] o_digest_word_d
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_PAD   = 7'b0000010,
        S_FILL  = 7'b0000100,
        S_PRE   = 7'b0001000,
        S_ROUND = 7'b0010000,
        S_ADD   = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state                r_state;
    logic [60:0]           r_cnt;
    md5_pkg::t_word        r_ha, r_hb, r_hc, r_hd;
    md5_pkg::t_word        r_a, r_b, r_c, r_d;
    md5_pkg::t_word        r_asm;
    md5_pkg::t_round       r_rnd;
    md5_pkg::t_widx        r_widx;
    logic                  r_fin, r_padded, r_two;
    logic                  r_ovalid;
    md5_pkg::t_word        r_oa, r_ob, r_oc, r_od;

    logic                  accept;
    logic [5:0]            pos;
    logic [63:0]           len;
    logic                  we;
    md5_pkg::t_widx        waddr, raddr;
    md5_pkg::t_word        wdata, rdata, new_b, part, asm_next;
    logic                  out_free;

    assign accept   = i_valid && !o_stall;
    assign o_stall  = (r_state != S_IDLE);
    assign pos      = r_cnt[5:0];
    assign len      = {r_cnt, 3'b000};
    assign out_free = !r_ovalid || !i_stall;

    always_comb begin
        asm_next = r_asm;
        asm_next[8*pos[1:0] +: 8] = i_data_byte;
        for (int k = 0; k < 4; k++) begin
            if (k < int'(pos[1:0])) begin
                part[8*k +: 8] = r_asm[8*k +: 8];
            end else if (k == int'(pos[1:0])) begin
                part[8*k +: 8] = md5_pkg::PAD_BYTE;
            end else begin
                part[8*k +: 8] = 8'h00;
            end
        end
    end

    always_comb begin
        we    = 1'b0;
        waddr = pos[5:2];
        wdata = asm_next;
        case (r_state)
            S_IDLE: begin
                we = accept && i_byte_valid && (pos[1:0] == 2'b11);
            end
            S_PAD: begin
                we    = 1'b1;
                wdata = part;
            end
            S_FILL: begin
                we    = 1'b1;
                waddr = r_widx;
                wdata = '0;
                if (!r_two && r_widx == 4'd14) begin
                    wdata = len[31:0];
                end else if (!r_two && r_widx == 4'd15) begin
                    wdata = len[63:32];
                end
            end
            default: we = 1'b0;
        endcase
        raddr = (r_state == S_ROUND) ? md5_pkg::round_g(r_rnd + 6'd1)
                                     : md5_pkg::round_g('0);
    end

    md5_ram #(
        .WIDTH(32),
        .DEPTH(md5_pkg::WORDS)
    ) u_block (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    md5_round u_round (
        .i_a  (r_a),
        .i_b  (r_b),
        .i_c  (r_c),
        .i_d  (r_d),
        .i_w  (rdata),
        .i_rnd(r_rnd),
        .o_b  (new_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_ha     <= md5_pkg::IV_A;
            r_hb     <= md5_pkg::IV_B;
            r_hc     <= md5_pkg::IV_C;
            r_hd     <= md5_pkg::IV_D;
            r_rnd    <= '0;
            r_widx   <= '0;
            r_fin    <= 1'b0;
            r_padded <= 1'b0;
            r_two    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_state == S_OUT && out_free) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_fin <= i_last;
                        if (i_byte_valid) begin
                            r_asm <= asm_next;
                            r_cnt <= r_cnt + 61'd1;
                            if (pos == 6'd63) begin
                                r_state <= S_PRE;
                            end else if (i_last) begin
                                r_state <= S_PAD;
                            end
                        end else if (i_last) begin
                            r_state <= S_PAD;
                        end
                    end
                end
                S_PAD: begin
                    r_padded <= 1'b1;
                    r_two    <= (pos[5:3] == 3'b111);
                    r_widx   <= pos[5:2] + 4'd1;
                    r_state  <= (pos[5:2] == 4'd15) ? S_PRE : S_FILL;
                end
                S_FILL: begin
                    r_widx <= r_widx + 4'd1;
                    if (r_widx == 4'd15) begin
                        r_state <= S_PRE;
                    end
                end
                S_PRE: begin
                    r_a     <= r_ha;
                    r_b     <= r_hb;
                    r_c     <= r_hc;
                    r_d     <= r_hd;
                    r_rnd   <= '0;
                    r_state <= S_ROUND;
                end
                S_ROUND: begin
                    r_a   <= r_d;
                    r_b   <= new_b;
                    r_c   <= r_b;
                    r_d   <= r_c;
                    r_rnd <= r_rnd + 6'd1;
                    if (r_rnd == 6'd63) begin
                        r_state <= S_ADD;
                    end
                end
                S_ADD: begin
                    r_ha <= r_ha + r_a;
                    r_hb <= r_hb + r_b;
                    r_hc <= r_hc + r_c;
                    r_hd <= r_hd + r_d;
                    if (!r_fin) begin
                        r_state <= S_IDLE;
                    end else if (!r_padded) begin
                        r_state <= S_PAD;
                    end else if (r_two) begin
                        r_two   <= 1'b0;
                        r_widx  <= '0;
                        r_state <= S_FILL;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_oa     <= r_ha;
                        r_ob     <= r_hb;
                        r_oc     <= r_hc;
                        r_od     <= r_hd;
                        r_ha     <= md5_pkg::IV_A;
                        r_hb     <= md5_pkg::IV_B;
                        r_hc     <= md5_pkg::IV_C;
                        r_hd     <= md5_pkg::IV_D;
                        r_cnt    <= '0;
                        r_fin    <= 1'b0;
                        r_padded <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid         = r_ovalid;
    assign o_digest_word_a = r_oa;
    assign o_digest_word_b = r_ob;
    assign o_digest_word_c = r_oc;
    assign o_digest_word_d = r_od;

endmodule

/* rtl/core/md5_ram.sv */
// ----------------------------------------------------------------------------
// MD5 generic RAM
// Simple dual-port memory with one write port and a registered read port.
// ----------------------------------------------------------------------------
module md5_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/md5_round.sv */
// ----------------------------------------------------------------------------
// MD5 round unit
// One MD5 round: mixing function, additions and rotation, producing the new
// B word from the working words, the message word and the round number.
// ----------------------------------------------------------------------------
module md5_round (
    input  md5_pkg::t_word  i_a,
    input  md5_pkg::t_word  i_b,
    input  md5_pkg::t_word  i_c,
    input  md5_pkg::t_word  i_d,
    input  md5_pkg::t_word  i_w,
    input  md5_pkg::t_round i_rnd,
    output md5_pkg::t_word  o_b
);

    md5_pkg::t_word f;
    md5_pkg::t_word sum;
    logic [4:0]     s;
    logic [63:0]    dbl;

    always_comb begin
        case (i_rnd[5:4])
            2'd0:    f = (i_b & i_c) | (~i_b & i_d);
            2'd1:    f = (i_d & i_b) | (~i_d & i_c);
            2'd2:    f = i_b ^ i_c ^ i_d;
            default: f = i_c ^ (i_b | ~i_d);
        endcase
        sum = i_a + f + md5_pkg::round_k(i_rnd) + i_w;
        s   = md5_pkg::round_s(i_rnd);
        dbl = {sum, sum} << s;
        o_b = i_b + dbl[63:32];
    end

endmodule
